>>> rtl/triangle_coverage_rasterizer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle coverage rasterizer
// Implication checks on the clock and asynchronous reset of the top level.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_COVERAGE_RASTERIZER_TOP_ASSERT_SVH
`define TRIANGLE_COVERAGE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TCR_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tcr assertion failed");

// Next-cycle implication.
`define TCR_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tcr assertion failed");

`endif

>>> rtl/tcr_pkg.sv
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared constants, widths and types of the triangle coverage rasterizer.
// ----------------------------------------------------------------------------
package tcr_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int LANES      = MAX_WIDTH;

	localparam int CW   = 23;  // screen coordinate, Q.12 signed
	localparam int DFW  = 24;  // coordinate difference
	localparam int COW  = 26;  // edge coefficient after sign fix
	localparam int DW   = 50;  // doubled area
	localparam int NW   = 56;  // edge numerators
	localparam int BXW  = 12;  // signed bounding box arithmetic
	localparam int PYW  = 25;  // row offset from the third vertex
	localparam int QW   = 29;  // area over the tolerance denominator

	// The absolute doubled area stays below 2^42, so dividing it by 10000 is a
	// shift by four followed by an exact reciprocal multiplication by 1/625.
	localparam int AREA_SHIFT = 4;
	localparam int UW   = 38;  // absolute area over 16
	localparam int UH   = 19;  // split point of the shifted area
	localparam int RW   = 39;  // reciprocal width
	localparam int RL   = 20;  // split point of the reciprocal
	localparam int RSH  = 48;  // scale of the reciprocal
	localparam int PRW  = UW + RW;
	localparam logic [RW-1:0] RECIP = 39'd450359962738;  // floor(2^48 / 625) + 1

	localparam logic signed [DW-1:0] DEGEN_LIM = 50'sd16;

	localparam int IDXW = 2;
	localparam logic [IDXW-1:0] REG_FB_WIDTH  = 2'd0;
	localparam logic [IDXW-1:0] REG_FB_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROW
	} eng_state_t;

	typedef struct packed {
		logic signed [COW-1:0] ca;
		logic signed [COW-1:0] cb;
		logic signed [COW-1:0] cg;
		logic signed [COW-1:0] ba;
		logic signed [COW-1:0] bb;
		logic signed [COW-1:0] bg;
		logic signed [NW-1:0]  ka;
		logic signed [NW-1:0]  kb;
		logic signed [NW-1:0]  kg;
		logic [DW-1:0]         dabs;
		logic signed [CW-1:0]  y2;
		logic [5:0]            minx;
		logic [6:0]            maxx;
		logic [5:0]            miny;
		logic [5:0]            lasty;
		logic                  degen;
		logic                  empty;
	} tri_t;

endpackage

>>> rtl/triangle_coverage_rasterizer_top.sv
// ----------------------------------------------------------------------------
// triangle_coverage_rasterizer_top
// Barycentric triangle rasterizer emitting one coverage mask per box row.
// ----------------------------------------------------------------------------
// A triangle passes a four-stage setup pipeline, then the row engine divides the
// doubled area by the tolerance denominator and issues one box row per cycle,
// while the output is not stalled, into a four-stage row pipeline; the single
// row issue port and the wait for the row pipeline to drain bound how soon the
// next triangle can be loaded. A new triangle is loaded only once the row
// pipeline has drained, and a triangle whose clipped box is empty is dropped
// after setup without output.
module triangle_coverage_rasterizer_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [95:0]             s_tdata,   // ax, ay, bx, by, cx, cy
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [87:0]             m_tdata,   // row, span_start, span_end, coverage
	output logic                    m_tlast,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [tcr_pkg::IDXW-1:0] cfg_index,
	input  logic [6:0]              cfg_data
);
	import tcr_pkg::*;

	logic [6:0] fb_w_q, fb_h_q;
	eng_state_t state_q, state_nx;
	tri_t       tri_s, tri_q;
	logic       tri_valid, take, start, issue;
	logic [5:0] j_q;
	logic signed [NW-1:0] lo_q, hi_q;
	logic       div_busy;
	logic [QW-1:0] quot;
	logic       adv, row_busy;
	logic [5:0] row;
	logic [LANES-1:0] coverage;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_w_q <= 7'(MAX_WIDTH);
			fb_h_q <= 7'(MAX_HEIGHT);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FB_WIDTH:  fb_w_q <= cfg_data;
				REG_FB_HEIGHT: fb_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tcr_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.fb_w      (fb_w_q),
		.fb_h      (fb_h_q),
		.out_valid (tri_valid),
		.out_take  (take),
		.out_tri   (tri_s)
	);

	tcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (tri_s.dabs[UW+AREA_SHIFT-1:AREA_SHIFT]),
		.busy     (div_busy),
		.quot     (quot)
	);

	always_comb begin
		state_nx = state_q;
		take     = 1'b0;
		start    = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (tri_valid && !row_busy) begin
					take = 1'b1;
					if (!tri_s.empty) begin
						start    = 1'b1;
						state_nx = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (!div_busy) state_nx = ST_ROW;
			end
			ST_ROW: begin
				if (adv) begin
					issue = 1'b1;
					if (j_q == tri_q.lasty) state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tri_q <= tri_s;
			j_q   <= tri_s.miny;
		end else if (issue) begin
			j_q <= j_q + 6'd1;
		end
		// A weight passes when -q <= N <= D + q, with q = floor(D / 10000).
		if (state_q == ST_DIV && !div_busy) begin
			lo_q <= -NW'(quot);
			hi_q <= NW'(tri_q.dabs) + NW'(quot);
		end
	end

	tcr_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.j         (j_q),
		.last_in   (j_q == tri_q.lasty),
		.tri_c     (tri_q),
		.lo        (lo_q),
		.hi        (hi_q),
		.adv       (adv),
		.busy      (row_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.row       (row),
		.coverage  (coverage),
		.last      (m_tlast)
	);

	assign m_tdata = {4'd0, coverage, tri_q.maxx, {1'b0, tri_q.minx}, row};

`include "triangle_coverage_rasterizer_top_assert.svh"

	`TCR_ASSERT_IMP(a_take_drained, take, !row_busy)
	`TCR_ASSERT_IMP(a_row_no_div, state_q == ST_ROW, !div_busy)
	`TCR_ASSERT_IMP(a_span_order, m_tvalid, {1'b0, tri_q.minx} < tri_q.maxx)
	`TCR_ASSERT_NXT(a_start_busy, start, div_busy && state_q == ST_DIV)

endmodule

>>> rtl/tcr_setup.sv
// ----------------------------------------------------------------------------
// tcr_setup
// Four-stage triangle setup: screen mapping, bounding box, area and edges.
// ----------------------------------------------------------------------------
module tcr_setup (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [95:0]           in_data,
	input  logic [6:0]            fb_w,
	input  logic [6:0]            fb_h,
	output logic                  out_valid,
	input  logic                  out_take,
	output tcr_pkg::tri_t         out_tri
);
	import tcr_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1: mapping to screen space.
	logic [6:0] w_c, h_c;
	logic [5:0] hw, hh;
	logic signed [CW-1:0] sx [3];
	logic signed [CW-1:0] sy [3];
	logic signed [CW-1:0] x_s1 [3];
	logic signed [CW-1:0] y_s1 [3];
	logic [6:0] w_s1, h_s1;

	always_comb begin
		w_c = (fb_w > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : fb_w;
		h_c = (fb_h > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : fb_h;
		hw  = w_c[6:1];
		hh  = h_c[6:1];
		for (int k = 0; k < 3; k++) begin
			sx[k] = CW'($signed(in_data[32*k +: 16]) * $signed({1'b0, hw}))
				+ CW'({hw, 12'd0});
			sy[k] = CW'({hh, 12'd0})
				- CW'($signed(in_data[32*k+16 +: 16]) * $signed({1'b0, hh}));
		end
	end

	// Stage 2: bounding box and differences.
	logic signed [CW-1:0]  xmin, xmax, ymin, ymax;
	logic signed [CW:0]    cxa, cya;
	logic signed [BXW-1:0] minx_w, maxx_w, miny_w, maxy_w, wl, hl;
	logic [5:0] minx_s2, miny_s2, lasty_s2;
	logic [6:0] maxx_s2;
	logic       empty_s2;
	logic signed [DFW-1:0] dy12_s2, dx21_s2, dx02_s2, dy20_s2, dy02_s2;
	logic signed [CW-1:0]  x2_s2, y2_s2;

	always_comb begin
		xmin = x_s1[0];
		xmax = x_s1[0];
		ymin = y_s1[0];
		ymax = y_s1[0];
		for (int k = 1; k < 3; k++) begin
			if (x_s1[k] < xmin) xmin = x_s1[k];
			if (x_s1[k] > xmax) xmax = x_s1[k];
			if (y_s1[k] < ymin) ymin = y_s1[k];
			if (y_s1[k] > ymax) ymax = y_s1[k];
		end
		minx_w = (xmin > 0) ? BXW'(xmin >>> 12) : '0;
		miny_w = (ymin > 0) ? BXW'(ymin >>> 12) : '0;
		// Ceiling of the maximum, plus one.
		cxa = (CW+1)'(xmax) + (CW+1)'(4095);
		cya = (CW+1)'(ymax) + (CW+1)'(4095);
		maxx_w = BXW'(cxa >>> 12) + BXW'(1);
		maxy_w = BXW'(cya >>> 12) + BXW'(1);
		wl = $signed({5'd0, w_s1});
		hl = $signed({5'd0, h_s1});
		if (maxx_w > wl) maxx_w = wl;
		if (maxy_w > hl) maxy_w = hl;
	end

	// Stage 3: doubled area and the vertex terms of the edge functions.
	logic signed [DW-1:0]  d_s3;
	logic signed [NW-1:0]  ka_s3, kb_s3;
	logic signed [DFW-1:0] dy12_s3, dx21_s3, dx02_s3, dy20_s3;
	logic [5:0] minx_s3, miny_s3, lasty_s3;
	logic [6:0] maxx_s3;
	logic       empty_s3;
	logic signed [CW-1:0] y2_s3;

	// Stage 4: orientation fix.
	logic                  neg;
	logic signed [COW-1:0] ca, cb, ba, bb;
	logic signed [NW-1:0]  ka, kb;
	logic [DW-1:0]         dabs;
	tri_t                  tri_s4;

	always_comb begin
		neg  = d_s3[DW-1];
		ca   = neg ? -COW'(dy12_s3) : COW'(dy12_s3);
		cb   = neg ? -COW'(dy20_s3) : COW'(dy20_s3);
		ba   = neg ? -COW'(dx21_s3) : COW'(dx21_s3);
		bb   = neg ? -COW'(dx02_s3) : COW'(dx02_s3);
		ka   = neg ? -ka_s3 : ka_s3;
		kb   = neg ? -kb_s3 : kb_s3;
		dabs = neg ? DW'(-d_s3) : DW'(d_s3);
	end

	assign en        = !v_s4 || out_take;
	assign in_ready  = en;
	assign out_valid = v_s4;
	assign out_tri   = tri_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= sx;
			y_s1     <= sy;
			w_s1     <= w_c;
			h_s1     <= h_c;

			minx_s2  <= minx_w[5:0];
			miny_s2  <= miny_w[5:0];
			maxx_s2  <= maxx_w[6:0];
			lasty_s2 <= 6'(maxy_w - BXW'(1));
			empty_s2 <= (minx_w >= maxx_w) || (miny_w >= maxy_w);
			dy12_s2  <= DFW'(y_s1[1]) - DFW'(y_s1[2]);
			dx21_s2  <= DFW'(x_s1[2]) - DFW'(x_s1[1]);
			dx02_s2  <= DFW'(x_s1[0]) - DFW'(x_s1[2]);
			dy20_s2  <= DFW'(y_s1[2]) - DFW'(y_s1[0]);
			dy02_s2  <= DFW'(y_s1[0]) - DFW'(y_s1[2]);
			x2_s2    <= x_s1[2];
			y2_s2    <= y_s1[2];

			d_s3     <= DW'(dy12_s2 * dx02_s2) + DW'(dx21_s2 * dy02_s2);
			ka_s3    <= -NW'(dy12_s2 * x2_s2);
			kb_s3    <= -NW'(dy20_s2 * x2_s2);
			dy12_s3  <= dy12_s2;
			dx21_s3  <= dx21_s2;
			dx02_s3  <= dx02_s2;
			dy20_s3  <= dy20_s2;
			minx_s3  <= minx_s2;
			miny_s3  <= miny_s2;
			maxx_s3  <= maxx_s2;
			lasty_s3 <= lasty_s2;
			empty_s3 <= empty_s2;
			y2_s3    <= y2_s2;

			tri_s4.ca    <= ca;
			tri_s4.cb    <= cb;
			tri_s4.cg    <= -(ca + cb);
			tri_s4.ba    <= ba;
			tri_s4.bb    <= bb;
			tri_s4.bg    <= -(ba + bb);
			tri_s4.ka    <= ka;
			tri_s4.kb    <= kb;
			tri_s4.kg    <= NW'(dabs) - ka - kb;
			tri_s4.dabs  <= dabs;
			tri_s4.y2    <= y2_s3;
			tri_s4.minx  <= minx_s3;
			tri_s4.maxx  <= maxx_s3;
			tri_s4.miny  <= miny_s3;
			tri_s4.lasty <= lasty_s3;
			tri_s4.degen <= (d_s3 <= DEGEN_LIM) && (d_s3 >= -DEGEN_LIM);
			tri_s4.empty <= empty_s3;
		end
	end

endmodule

>>> rtl/tcr_div.sv
// ----------------------------------------------------------------------------
// tcr_div
// Area over the tolerance denominator by reciprocal multiplication.
// ----------------------------------------------------------------------------
module tcr_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [tcr_pkg::UW-1:0] dividend,
	output logic                   busy,
	output logic [tcr_pkg::QW-1:0] quot
);
	import tcr_pkg::*;

	logic [UW-1:0]    u_q;
	logic [2*UH-1:0]  pp_hh_q;
	logic [UH+RL-1:0] pp_hl_q;
	logic [2*UH-1:0]  pp_lh_q;
	logic [UH+RL-1:0] pp_ll_q;
	logic [PRW-1:0]   prod;
	logic [QW-1:0]    quot_q;
	logic             busy_q;
	logic             ph_q;

	// The dividend is already the area over 16; the reciprocal of 625 is exact
	// for every dividend of UW bits. Four partial products are registered first,
	// then their sum is formed and its integer part registered.
	always_comb begin
		prod = (PRW'(pp_hh_q) << (UH + RL)) + (PRW'(pp_hl_q) << UH)
			+ (PRW'(pp_lh_q) << RL) + PRW'(pp_ll_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			ph_q   <= 1'b0;
		end else if (busy_q) begin
			ph_q <= 1'b1;
			if (ph_q) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) u_q <= dividend;
		if (busy_q && !ph_q) begin
			pp_hh_q <= u_q[UW-1:UH] * RECIP[RW-1:RL];
			pp_hl_q <= u_q[UW-1:UH] * RECIP[RL-1:0];
			pp_lh_q <= u_q[UH-1:0] * RECIP[RW-1:RL];
			pp_ll_q <= u_q[UH-1:0] * RECIP[RL-1:0];
		end
		if (busy_q && ph_q) quot_q <= prod[PRW-1:RSH];
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

>>> rtl/tcr_row.sv
// ----------------------------------------------------------------------------
// tcr_row
// Four-stage row pipeline: row offset, row terms, lane numerators, coverage.
// ----------------------------------------------------------------------------
module tcr_row (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          issue,
	input  logic [5:0]                    j,
	input  logic                          last_in,
	input  tcr_pkg::tri_t                 tri_c,
	input  logic signed [tcr_pkg::NW-1:0] lo,
	input  logic signed [tcr_pkg::NW-1:0] hi,
	output logic                          adv,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [5:0]                    row,
	output logic [tcr_pkg::LANES-1:0]     coverage,
	output logic                          last
);
	import tcr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [5:0] j_s1, j_s2, j_s3, j_s4;
	logic l_s1, l_s2, l_s3, l_s4;
	logic signed [PYW-1:0] py_s1;
	logic signed [NW-1:0]  ra_s2, rb_s2, rg_s2;
	logic signed [NW-1:0]  na_s3 [LANES];
	logic signed [NW-1:0]  nb_s3 [LANES];
	logic signed [NW-1:0]  ng_s3 [LANES];
	logic [LANES-1:0]      cov_s4;
	logic signed [NW-1:0]  na_c [LANES];
	logic signed [NW-1:0]  nb_c [LANES];
	logic signed [NW-1:0]  ng_c [LANES];
	logic [LANES-1:0]      cov_c;

	assign adv  = !v_s4 || out_ready;
	assign busy = v_s1 || v_s2 || v_s3 || v_s4;

	// Each lane is one absolute column; its edge values grow linearly with it.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			na_c[i] = (NW'(tri_c.ca * $signed({1'b0, 7'(i)})) <<< 12) + ra_s2;
			nb_c[i] = (NW'(tri_c.cb * $signed({1'b0, 7'(i)})) <<< 12) + rb_s2;
			ng_c[i] = (NW'(tri_c.cg * $signed({1'b0, 7'(i)})) <<< 12) + rg_s2;
			cov_c[i] = !tri_c.degen
				&& (7'(i) >= {1'b0, tri_c.minx}) && (7'(i) < tri_c.maxx)
				&& (na_s3[i] >= lo) && (na_s3[i] <= hi)
				&& (nb_s3[i] >= lo) && (nb_s3[i] <= hi)
				&& (ng_s3[i] >= lo) && (ng_s3[i] <= hi);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			j_s1  <= j;
			l_s1  <= last_in;
			py_s1 <= PYW'({j, 12'd0}) - PYW'(tri_c.y2);
			j_s2  <= j_s1;
			l_s2  <= l_s1;
			ra_s2 <= NW'(tri_c.ba * py_s1) + tri_c.ka;
			rb_s2 <= NW'(tri_c.bb * py_s1) + tri_c.kb;
			rg_s2 <= NW'(tri_c.bg * py_s1) + tri_c.kg;
			j_s3  <= j_s2;
			l_s3  <= l_s2;
			na_s3 <= na_c;
			nb_s3 <= nb_c;
			ng_s3 <= ng_c;
			j_s4  <= j_s3;
			l_s4  <= l_s3;
			cov_s4 <= cov_c;
		end
	end

	assign out_valid = v_s4;
	assign row       = j_s4;
	assign coverage  = cov_s4;
	assign last      = l_s4;

endmodule
